### rtl/core/sra_pkg.sv
`timescale 1ns / 1ps

package sra_pkg;

	localparam int SEQ_MODULUS = 1024;

	localparam int FUNC_W  = 2;
	localparam int SEQ_W   = 10;
	localparam int TIME_W  = 63;
	localparam int HASH_W  = 32;
	localparam int KIND_W  = 2;

	// s_tdata: seq_number, send_time, msg_hash, kill_number (115 bits, padded)
	localparam int S_TDATA_W = 120;
	localparam int S_TUSER_W = 3;
	// m_tdata: reply_seq, reply_hash, reply_time (105 bits, padded)
	localparam int M_TDATA_W = 112;
	localparam int M_TUSER_W = 3;

	localparam logic [FUNC_W-1:0] FUNC_DATA = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SYNC = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_BAD  = 2'd2;

	localparam logic [KIND_W-1:0] REPLY_NONE = 2'd0;
	localparam logic [KIND_W-1:0] REPLY_ACK  = 2'd1;
	localparam logic [KIND_W-1:0] REPLY_BAD  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SEQ_W-1:0]  seq_number;
		logic [TIME_W-1:0] send_time;
		logic [HASH_W-1:0] msg_hash;
		logic              has_kill;
		logic [SEQ_W-1:0]  kill_number;
	} item_t;

	typedef struct packed {
		logic              accepted;
		logic [KIND_W-1:0] reply_kind;
		logic [SEQ_W-1:0]  reply_seq;
		logic [HASH_W-1:0] reply_hash;
		logic [TIME_W-1:0] reply_time;
	} result_t;

endpackage

### rtl/core/sra_mod.sv
`timescale 1ns / 1ps

// Reduce an 11-bit value modulo SEQ_MODULUS and keep the low 10 bits.
// Split into a 5-bit high part and a 6-bit low part, look both up in
// constant residue tables, then one compare and subtract.
module sra_mod #(
	parameter int SEQ_MODULUS = sra_pkg::SEQ_MODULUS
) (
	input  logic [sra_pkg::SEQ_W:0]   x,
	output logic [sra_pkg::SEQ_W-1:0] r
);

	localparam int MW = $clog2(SEQ_MODULUS + 1);
	localparam int CW = (MW > 12) ? MW : 12;
	localparam logic [CW-1:0] MOD_C = CW'(SEQ_MODULUS);
	localparam int HI_N = 17;
	localparam int LO_N = 64;

	logic [10:0]   hi_tbl [HI_N];
	logic [5:0]    lo_tbl [LO_N];
	logic [CW-1:0] sum;
	logic [CW-1:0] red;

	for (genvar i = 0; i < HI_N; i++) begin : g_hi
		localparam int HV = (i * LO_N) % SEQ_MODULUS;
		assign hi_tbl[i] = 11'(HV);
	end

	for (genvar i = 0; i < LO_N; i++) begin : g_lo
		localparam int LV = i % SEQ_MODULUS;
		assign lo_tbl[i] = 6'(LV);
	end

	always_comb begin
		sum = CW'(hi_tbl[x[10:6]]) + CW'(lo_tbl[x[5:0]]);
		red = (sum >= MOD_C) ? (sum - MOD_C) : sum;
		r   = red[sra_pkg::SEQ_W-1:0];
	end

endmodule

### rtl/core/sra_decide.sv
`timescale 1ns / 1ps

// Link state and the per-header decision. State advances on fire.
module sra_decide #(
	parameter int SEQ_MODULUS = sra_pkg::SEQ_MODULUS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  sra_pkg::item_t   item,
	output sra_pkg::result_t res
);

	logic [sra_pkg::SEQ_W-1:0]  exp_q;
	logic                       in_sync_q;
	logic [sra_pkg::TIME_W-1:0] last_sync_time_q;
	logic [sra_pkg::SEQ_W-1:0]  resync_q;

	logic                      is_sync, is_data, new_sync, in_order, skip, bad;
	logic [sra_pkg::SEQ_W:0]   next_x;
	logic [sra_pkg::SEQ_W-1:0] next_seq;
	logic [sra_pkg::SEQ_W-1:0] resync_mod;

	always_comb begin
		is_sync  = (item.func == sra_pkg::FUNC_SYNC);
		is_data  = (item.func == sra_pkg::FUNC_DATA);
		new_sync = is_sync && !(in_sync_q && (item.send_time == last_sync_time_q));
		bad      = is_data && !in_sync_q;
		in_order = is_data && in_sync_q && (item.seq_number == exp_q);
		// plain compares, no wraparound
		skip     = is_data && in_sync_q && !in_order && item.has_kill
			&& (item.kill_number < exp_q) && (item.seq_number > exp_q);
		next_x   = in_order ? ({1'b0, exp_q} + 11'd1) : ({1'b0, item.seq_number} + 11'd1);
	end

	sra_mod #(.SEQ_MODULUS(SEQ_MODULUS)) u_next (
		.x(next_x),
		.r(next_seq)
	);

	sra_mod #(.SEQ_MODULUS(SEQ_MODULUS)) u_resync (
		.x({1'b0, resync_q}),
		.r(resync_mod)
	);

	always_comb begin
		res            = '0;
		res.accepted   = in_order || skip;
		if (new_sync) begin
			res.reply_kind = sra_pkg::REPLY_ACK;
			res.reply_seq  = item.seq_number;
			res.reply_hash = item.msg_hash;
		end else if (bad) begin
			res.reply_kind = sra_pkg::REPLY_BAD;
			res.reply_seq  = resync_mod;
			res.reply_time = item.send_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q            <= '0;
			in_sync_q        <= 1'b0;
			last_sync_time_q <= '0;
			resync_q         <= '0;
		end else if (fire) begin
			if (new_sync) begin
				exp_q            <= next_seq;
				in_sync_q        <= 1'b1;
				last_sync_time_q <= item.send_time;
				resync_q         <= resync_q + 10'd1;
			end else if (in_order || skip) begin
				exp_q <= next_seq;
			end
		end
	end

endmodule

### rtl/core/sequenced_receiver_acceptance.sv
`timescale 1ns / 1ps
// A header taken into the input register is decided against the link state and
// registered into the result register once that register is empty or being
// drained; the result beat is then offered on the master side.
// Throughput: one header per cycle while the master side is not stalled; the
// link state is read and updated in the single stage between the two registers.
// Reset (arst_n low) empties both registers and clears the link state.
module sequenced_receiver_acceptance #(
	parameter int SEQ_MODULUS = sra_pkg::SEQ_MODULUS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// seq_number[9:0], send_time[72:10], msg_hash[104:73], kill_number[114:105]
	input  logic [sra_pkg::S_TDATA_W-1:0]   s_tdata,
	// func[1:0], has_kill[2]
	input  logic [sra_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// reply_seq[9:0], reply_hash[41:10], reply_time[104:42]
	output logic [sra_pkg::M_TDATA_W-1:0]   m_tdata,
	// accepted[0], reply_kind[2:1]
	output logic [sra_pkg::M_TUSER_W-1:0]   m_tuser
);

	logic             valid_s1;
	sra_pkg::item_t   item_s1;
	logic             valid_s2;
	sra_pkg::result_t res_s2;

	sra_pkg::item_t   item_in;
	sra_pkg::result_t res;
	logic             advance;

	always_comb begin
		item_in.func        = s_tuser[1:0];
		item_in.has_kill    = s_tuser[2];
		item_in.seq_number  = s_tdata[9:0];
		item_in.send_time   = s_tdata[72:10];
		item_in.msg_hash    = s_tdata[104:73];
		item_in.kill_number = s_tdata[114:105];
	end

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	sra_decide #(.SEQ_MODULUS(SEQ_MODULUS)) u_decide (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.item(item_s1),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.reply_time, res_s2.reply_hash, res_s2.reply_seq};
	assign m_tuser  = {res_s2.reply_kind, res_s2.accepted};

endmodule

### rtl/core/sra_chk.sv
`timescale 1ns / 1ps

module sra_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [sra_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [sra_pkg::M_TUSER_W-1:0] m_tuser
);

	// hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// a ready sink never holds back the input side
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while the sink is ready");

	// an accepted message never triggers a reply
	a_acc_no_reply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == sra_pkg::REPLY_NONE)
		else $error("accepted message with a reply");

	// hash only echoed in an ack
	a_hash: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:1] != sra_pkg::REPLY_ACK |-> m_tdata[41:10] == '0)
		else $error("hash outside an ack");

	// timestamp only echoed in a bad request
	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:1] != sra_pkg::REPLY_BAD |-> m_tdata[104:42] == '0)
		else $error("timestamp outside a bad request");

endmodule

bind sequenced_receiver_acceptance sra_chk u_sra_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam logic [sra_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int RESET_CYCLES = 12;
	localparam int MAX_IDLE = 18;
	localparam int RANDOM_HEADERS = 750;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT = 600;

	typedef struct packed {
		logic [sra_pkg::SEQ_W-1:0]  expect_seq;
		logic                       synced;
		logic [sra_pkg::TIME_W-1:0] sync_time;
		logic [sra_pkg::SEQ_W-1:0]  resyncs;
	} link_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [sra_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [sra_pkg::S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [sra_pkg::M_TDATA_W-1:0] m_tdata;
	logic [sra_pkg::M_TUSER_W-1:0] m_tuser;

	sra_pkg::item_t   hdr_q[$];
	sra_pkg::result_t reply_q[$];
	sra_pkg::item_t   hdr_now;
	link_t   link_gen;
	link_t   link_seen;
	int      send_gap = 0;
	int      sink_wait = 0;
	bit      src_calm = 1'b0;
	bit      sink_calm = 1'b0;
	int      mismatches = 0;
	int      idle_cycles = 0;

	sequenced_receiver_acceptance dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	function automatic logic [sra_pkg::SEQ_W-1:0] seq_after(
			input logic [sra_pkg::SEQ_W-1:0] s);
		return sra_pkg::SEQ_W'((int'(s) + 1) % sra_pkg::SEQ_MODULUS);
	endfunction

	// Decide one header against the link state and advance that state.
	function automatic sra_pkg::result_t judge_header(inout link_t st,
			input sra_pkg::item_t h);
		sra_pkg::result_t r;
		r = '0;
		case (h.func)
			sra_pkg::FUNC_SYNC: begin
				if (!(st.synced && h.send_time == st.sync_time)) begin
					st.expect_seq = seq_after(h.seq_number);
					st.sync_time = h.send_time;
					st.resyncs = st.resyncs + 1'b1;
					st.synced = 1'b1;
					r.reply_kind = sra_pkg::REPLY_ACK;
					r.reply_seq = h.seq_number;
					r.reply_hash = h.msg_hash;
				end
			end
			sra_pkg::FUNC_DATA: begin
				if (!st.synced) begin
					r.reply_kind = sra_pkg::REPLY_BAD;
					r.reply_seq = sra_pkg::SEQ_W'(int'(st.resyncs) % sra_pkg::SEQ_MODULUS);
					r.reply_time = h.send_time;
				end else if (h.seq_number == st.expect_seq) begin
					st.expect_seq = seq_after(st.expect_seq);
					r.accepted = 1'b1;
				end else if (h.has_kill && h.kill_number < st.expect_seq
						&& h.seq_number > st.expect_seq) begin
					st.expect_seq = seq_after(h.seq_number);
					r.accepted = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int draw_gap(input bit calm);
		if (calm || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(0, MAX_IDLE);
	endfunction

	function automatic sra_pkg::item_t random_header();
		sra_pkg::item_t h;
		h.func = sra_pkg::FUNC_W'($urandom);
		h.seq_number = sra_pkg::SEQ_W'($urandom);
		h.send_time = sra_pkg::TIME_W'({$urandom, $urandom});
		h.msg_hash = $urandom;
		h.has_kill = 1'($urandom);
		h.kill_number = sra_pkg::SEQ_W'($urandom);
		return h;
	endfunction

	task automatic queue_header(input sra_pkg::item_t h);
		void'(judge_header(link_gen, h));
		hdr_q = {hdr_q, h};
	endtask

	task automatic add_header(input logic [sra_pkg::FUNC_W-1:0] f, input int seq,
			input logic [sra_pkg::TIME_W-1:0] t, input logic [sra_pkg::HASH_W-1:0] hash,
			input bit hk, input int kill);
		sra_pkg::item_t h;
		h.func = f;
		h.seq_number = sra_pkg::SEQ_W'(seq);
		h.send_time = t;
		h.msg_hash = hash;
		h.has_kill = hk;
		h.kill_number = sra_pkg::SEQ_W'(kill);
		queue_header(h);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
			mismatches++;
		end
	endtask

	// driver: present headers, count accepted beats into the predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				reply_q = {reply_q, judge_header(link_seen, hdr_now)};
				if ($urandom_range(0, 39) == 0)
					src_calm = !src_calm;
				send_gap = draw_gap(src_calm);
				if (send_gap == 0 && hdr_q.size() > 0) begin
					hdr_now = hdr_q[0];
					hdr_q.delete(0);
					s_tdata <= {5'b0, hdr_now.kill_number, hdr_now.msg_hash,
						hdr_now.send_time, hdr_now.seq_number};
					s_tuser <= {hdr_now.has_kill, hdr_now.func};
				end else begin
					s_tvalid <= 1'b0;
				end
			end else if (!s_tvalid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (hdr_q.size() > 0) begin
					hdr_now = hdr_q[0];
					hdr_q.delete(0);
					s_tdata <= {5'b0, hdr_now.kill_number, hdr_now.msg_hash,
						hdr_now.send_time, hdr_now.seq_number};
					s_tuser <= {hdr_now.has_kill, hdr_now.func};
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// monitor: compare each reply beat with the oldest prediction
	always @(posedge clk) begin
		sra_pkg::result_t got;
		sra_pkg::result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.reply_seq = m_tdata[9:0];
				got.reply_hash = m_tdata[41:10];
				got.reply_time = m_tdata[104:42];
				got.accepted = m_tuser[0];
				got.reply_kind = m_tuser[2:1];
				if (reply_q.size() == 0) begin
					$display("%0t: unexpected reply beat, expected none actual %0h",
						$realtime, got);
					mismatches++;
				end else begin
					want = reply_q[0];
					reply_q.delete(0);
					check_field("accepted", 64'(want.accepted), 64'(got.accepted));
					check_field("reply_kind", 64'(want.reply_kind), 64'(got.reply_kind));
					check_field("reply_seq", 64'(want.reply_seq), 64'(got.reply_seq));
					check_field("reply_hash", 64'(want.reply_hash), 64'(got.reply_hash));
					check_field("reply_time", 64'(want.reply_time), 64'(got.reply_time));
				end
				if ($urandom_range(0, 39) == 0)
					sink_calm = !sink_calm;
				sink_wait = draw_gap(sink_calm);
				if (sink_wait > 0)
					m_tready <= 1'b0;
			end else if (!m_tready) begin
				if (sink_wait > 0)
					sink_wait--;
				else
					m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("sequenced_receiver_acceptance test failed");
				$finish;
			end
		end
	end

	initial begin
		sra_pkg::item_t h;
		int exp_now;
		link_gen = '0;
		link_seen = '0;

		// before any sync: data draws a bad request, others are dropped
		add_header(sra_pkg::FUNC_DATA, 1023, '1, '1, 1'b1, 1023);
		add_header(sra_pkg::FUNC_DATA, 0, '0, '0, 1'b0, 0);
		add_header(sra_pkg::FUNC_BAD, 7, 123, 32'h55, 1'b1, 0);
		add_header(FUNC_UNUSED, 9, 77, 32'h1234, 1'b0, 3);
		// first sync at time zero is new; a repeat of it is dropped
		add_header(sra_pkg::FUNC_SYNC, 1023, '0, 32'hA5A5_5A5A, 1'b0, 0);
		add_header(sra_pkg::FUNC_SYNC, 5, '0, 32'h0F0F_F0F0, 1'b1, 1);
		add_header(sra_pkg::FUNC_DATA, 0, 1, 32'h1, 1'b0, 0);
		add_header(sra_pkg::FUNC_DATA, 0, 2, 32'h2, 1'b0, 0);
		add_header(sra_pkg::FUNC_DATA, 5, 3, 32'h3, 1'b1, 0);
		add_header(sra_pkg::FUNC_DATA, 9, 4, 32'h4, 1'b1, 6);
		add_header(sra_pkg::FUNC_DATA, 9, 5, 32'h5, 1'b1, 8);
		add_header(sra_pkg::FUNC_DATA, 9, 6, 32'h6, 1'b0, 0);
		add_header(sra_pkg::FUNC_DATA, 3, 7, 32'h7, 1'b1, 0);
		// wrap of the expected number through the top
		add_header(sra_pkg::FUNC_SYNC, 1022, '1, '1, 1'b0, 1023);
		add_header(sra_pkg::FUNC_DATA, 1023, 8, 32'h8, 1'b0, 0);
		add_header(sra_pkg::FUNC_DATA, 1023, 9, 32'h9, 1'b1, 0);
		add_header(sra_pkg::FUNC_SYNC, 0, '1, 32'hDEAD_BEEF, 1'b0, 0);
		add_header(sra_pkg::FUNC_SYNC, 100, 1, 32'hCAFE_F00D, 1'b1, 1023);
		add_header(sra_pkg::FUNC_DATA, 1023, 10, 32'hA, 1'b1, 100);
		add_header(sra_pkg::FUNC_BAD, 0, '1, '1, 1'b1, 0);
		add_header(FUNC_UNUSED, 1, '1, '1, 1'b1, 1023);
		add_header(sra_pkg::FUNC_DATA, 0, 11, 32'hB, 1'b1, 1023);

		repeat (RANDOM_HEADERS) begin
			h = random_header();
			exp_now = int'(link_gen.expect_seq);
			case ($urandom_range(0, 99)) inside
				[0:54]: begin
					h.func = sra_pkg::FUNC_DATA;
					h.seq_number = link_gen.expect_seq;
				end
				[55:64]: begin
					h.func = sra_pkg::FUNC_DATA;
					if (exp_now < 1023)
						h.seq_number = sra_pkg::SEQ_W'($urandom_range(exp_now + 1, 1023));
					h.has_kill = 1'b1;
					if (exp_now > 0)
						h.kill_number = sra_pkg::SEQ_W'($urandom_range(0, exp_now - 1));
				end
				[65:71]: h.func = sra_pkg::FUNC_SYNC;
				[72:76]: begin
					h.func = sra_pkg::FUNC_SYNC;
					h.send_time = link_gen.sync_time;
				end
				[77:79]: begin
					h.func = sra_pkg::FUNC_DATA;
					if (exp_now > 0)
						h.seq_number = sra_pkg::SEQ_W'($urandom_range(0, exp_now - 1));
				end
				[80:83]: begin
					h.func = sra_pkg::FUNC_DATA;
					if (exp_now < 1023)
						h.seq_number = sra_pkg::SEQ_W'($urandom_range(exp_now + 1, 1023));
					h.has_kill = 1'b1;
					h.kill_number = sra_pkg::SEQ_W'($urandom_range(exp_now, 1023));
				end
				[84:87]: h.func = ($urandom_range(0, 1) != 0) ? sra_pkg::FUNC_BAD
					: FUNC_UNUSED;
				default: ;
			endcase
			queue_header(h);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (hdr_q.size() != 0 || s_tvalid || reply_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("sequenced_receiver_acceptance test passed");
		else
			$display("sequenced_receiver_acceptance test failed");
		$finish;
	end

endmodule
